### rtl/three_lane_priority_queue_top_defines.svh
// Assertion macros for the three-lane priority queue checker.
`ifndef THREE_LANE_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define THREE_LANE_PRIORITY_QUEUE_TOP_DEFINES_SVH

// cons must hold in the cycle after ante
`define TLPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// cons must hold in the same cycle as ante
`define TLPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/tlpq_pkg.sv
// Types, constants and pointer helpers for the three-lane priority queue.
`default_nettype none

package tlpq_pkg;

    localparam int FAST_DEPTH   = 32;
    localparam int SLOW_DEPTH   = 128;
    localparam int NORMAL_DEPTH = 1024;
    localparam int ITEM_WIDTH   = 32;

    localparam int HANDLE_W       = 32;
    localparam int PRI_W          = 8;
    localparam int THR_W          = 6;
    localparam int FAST_CAP_W     = 6;
    localparam int SLOW_CAP_W     = 8;
    localparam int NORMAL_CAP_W   = 11;
    localparam int FAST_COUNT_W   = 6;
    localparam int SLOW_COUNT_W   = 8;
    localparam int NORMAL_COUNT_W = 11;
    localparam int CFG_DATA_W     = 11;
    localparam int CFG_INDEX_W    = 2;

    localparam int FAST_AW   = (FAST_DEPTH > 1) ? $clog2(FAST_DEPTH) : 1;
    localparam int SLOW_AW   = (SLOW_DEPTH > 1) ? $clog2(SLOW_DEPTH) : 1;
    localparam int NORMAL_AW = (NORMAL_DEPTH > 1) ? $clog2(NORMAL_DEPTH) : 1;
    localparam int FAST_CW   = $clog2(FAST_DEPTH + 1);
    localparam int SLOW_CW   = $clog2(SLOW_DEPTH + 1);
    localparam int NORMAL_CW = $clog2(NORMAL_DEPTH + 1);

    // wide enough for pointer plus count at the largest lane depth
    localparam int PTR_SUM_W = 18;

    typedef enum logic [1:0] {
        LANE_FAST   = 2'd0,
        LANE_SLOW   = 2'd1,
        LANE_NORMAL = 2'd2
    } lane_t;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THRESHOLD  = 2'd0,
        CFG_FAST_CAP   = 2'd1,
        CFG_SLOW_CAP   = 2'd2,
        CFG_NORMAL_CAP = 2'd3
    } cfg_index_t;

    localparam logic [PRI_W-1:0] PRI_FAST = 8'h00;
    localparam logic [PRI_W-1:0] PRI_SLOW = 8'h01;

    localparam logic [THR_W-1:0]        THR_RESET        = 6'd17;
    localparam logic [FAST_CAP_W-1:0]   FAST_CAP_RESET   = 6'd17;
    localparam logic [SLOW_CAP_W-1:0]   SLOW_CAP_RESET   = 8'd68;
    localparam logic [NORMAL_CAP_W-1:0] NORMAL_CAP_RESET = 11'd1000;

    // base + step folded back into [0, depth); base + step < 2 * depth
    function automatic logic [PTR_SUM_W-1:0] ptr_add(
        input logic [PTR_SUM_W-1:0] base,
        input logic [PTR_SUM_W-1:0] step,
        input logic [PTR_SUM_W-1:0] depth
    );
        logic [PTR_SUM_W-1:0] sum;
        sum = base + step;
        return (sum >= depth) ? sum - depth : sum;
    endfunction

endpackage

`default_nettype wire

### rtl/tlpq_ram.sv
// Simple dual-port lane RAM with registered read and write-through on a colliding read.
`default_nettype none

module tlpq_ram #(
    parameter int DEPTH  = 32,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/three_lane_priority_queue_top.sv
// Three-lane strict-priority drop-tail queue: input stage, lane control and result register.
//
// Takes one word (enqueue or dequeue) in every cycle; busy is always low. A word accepted at
// one clock edge is applied to the lanes at the next edge, and its result is shown with done
// high in the cycle after that edge, for that one cycle only: the receiver cannot stall and
// must take it then. The one-word-per-cycle rate is set by each lane's head cache, which is
// refilled from the lane RAM read port aimed at the entry behind the head. The lane RAMs are
// not cleared; no clearing pass follows reset. Configuration is written through cfg_we while
// no word is in flight.
`default_nettype none

module three_lane_priority_queue_top
    import tlpq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                      opcode,
    input  logic                      tag_present,
    input  logic [PRI_W-1:0]          priority_value,
    input  logic [HANDLE_W-1:0]       item_handle,
    output logic                      done,
    output logic                      accepted,
    output logic [1:0]                lane_used,
    output logic                      out_valid,
    output logic [HANDLE_W-1:0]       out_item,
    output logic                      head_valid,
    output logic [HANDLE_W-1:0]       head_item,
    output logic [FAST_COUNT_W-1:0]   fast_count,
    output logic [SLOW_COUNT_W-1:0]   slow_count,
    output logic [NORMAL_COUNT_W-1:0] normal_count
);

    // input stage
    logic                  valid_reg;
    op_t                   op_reg;
    logic                  tag_reg;
    logic [PRI_W-1:0]      pri_reg;
    logic [ITEM_WIDTH-1:0] handle_reg;

    // configuration
    logic [THR_W-1:0]        thr_reg;
    logic [FAST_CAP_W-1:0]   fast_cap_reg;
    logic [SLOW_CAP_W-1:0]   slow_cap_reg;
    logic [NORMAL_CAP_W-1:0] normal_cap_reg;

    // lane state: read pointer, count, cached head entry
    logic [FAST_AW-1:0]    fast_head_reg, fast_head_next;
    logic [FAST_CW-1:0]    fast_cnt_reg, fast_cnt_next;
    logic [ITEM_WIDTH-1:0] fast_hval_reg, fast_hval_next;
    logic [SLOW_AW-1:0]    slow_head_reg, slow_head_next;
    logic [SLOW_CW-1:0]    slow_cnt_reg, slow_cnt_next;
    logic [ITEM_WIDTH-1:0] slow_hval_reg, slow_hval_next;
    logic [NORMAL_AW-1:0]  normal_head_reg, normal_head_next;
    logic [NORMAL_CW-1:0]  normal_cnt_reg, normal_cnt_next;
    logic [ITEM_WIDTH-1:0] normal_hval_reg, normal_hval_next;

    // RAM ports
    logic [FAST_AW-1:0]    fast_waddr, fast_raddr;
    logic [SLOW_AW-1:0]    slow_waddr, slow_raddr;
    logic [NORMAL_AW-1:0]  normal_waddr, normal_raddr;
    logic [ITEM_WIDTH-1:0] fast_rdata, slow_rdata, normal_rdata;

    // step decode
    logic  enq, deq;
    lane_t sel_lane;
    logic  fast_full, slow_full, normal_full;
    logic  fast_nz, slow_nz, normal_nz;
    logic  fast_push, slow_push, normal_push;
    logic  fast_pop, slow_pop, normal_pop;

    // result register
    logic                  done_reg;
    logic                  accepted_reg, accepted_next;
    lane_t                 lane_reg, lane_next;
    logic                  out_valid_reg, out_valid_next;
    logic [ITEM_WIDTH-1:0] out_item_reg, out_item_next;
    logic                  head_valid_reg, head_valid_next;
    logic [ITEM_WIDTH-1:0] head_item_reg, head_item_next;
    logic [FAST_CW-1:0]    fast_count_reg;
    logic [SLOW_CW-1:0]    slow_count_reg;
    logic [NORMAL_CW-1:0]  normal_count_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg     <= op_t'(opcode);
            tag_reg    <= tag_present;
            pri_reg    <= priority_value;
            handle_reg <= ITEM_WIDTH'(item_handle);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= THR_RESET;
            fast_cap_reg   <= FAST_CAP_RESET;
            slow_cap_reg   <= SLOW_CAP_RESET;
            normal_cap_reg <= NORMAL_CAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_THRESHOLD:  thr_reg        <= THR_W'(cfg_wdata);
                CFG_FAST_CAP:   fast_cap_reg   <= FAST_CAP_W'(cfg_wdata);
                CFG_SLOW_CAP:   slow_cap_reg   <= SLOW_CAP_W'(cfg_wdata);
                CFG_NORMAL_CAP: normal_cap_reg <= NORMAL_CAP_W'(cfg_wdata);
                default:        thr_reg        <= thr_reg;
            endcase
        end
    end

    // classification and lane selection
    assign enq = valid_reg && (op_reg == OP_ENQUEUE);
    assign deq = valid_reg && (op_reg == OP_DEQUEUE);

    always_comb
    begin
        sel_lane = LANE_NORMAL;
        if (tag_reg)
        begin
            if (pri_reg == PRI_FAST)
            begin
                sel_lane = LANE_FAST;
            end
            else if (pri_reg == PRI_SLOW)
            begin
                sel_lane = LANE_SLOW;
            end
        end
        if ((sel_lane == LANE_FAST) && (fast_cnt_reg >= thr_reg))
        begin
            sel_lane = LANE_SLOW;
        end
    end

    assign fast_full   = (fast_cnt_reg >= fast_cap_reg) ||
                         (fast_cnt_reg == FAST_CW'(FAST_DEPTH));
    assign slow_full   = (slow_cnt_reg >= slow_cap_reg) ||
                         (slow_cnt_reg == SLOW_CW'(SLOW_DEPTH));
    assign normal_full = (normal_cnt_reg >= normal_cap_reg) ||
                         (normal_cnt_reg == NORMAL_CW'(NORMAL_DEPTH));

    assign fast_nz   = (fast_cnt_reg != '0);
    assign slow_nz   = (slow_cnt_reg != '0);
    assign normal_nz = (normal_cnt_reg != '0);

    assign fast_push   = enq && (sel_lane == LANE_FAST) && !fast_full;
    assign slow_push   = enq && (sel_lane == LANE_SLOW) && !slow_full;
    assign normal_push = enq && (sel_lane == LANE_NORMAL) && !normal_full;

    assign fast_pop   = deq && fast_nz;
    assign slow_pop   = deq && !fast_nz && slow_nz;
    assign normal_pop = deq && !fast_nz && !slow_nz && normal_nz;

    // tail address = head + count, folded
    assign fast_waddr   = FAST_AW'(ptr_add(PTR_SUM_W'(fast_head_reg),
                          PTR_SUM_W'(fast_cnt_reg), PTR_SUM_W'(FAST_DEPTH)));
    assign slow_waddr   = SLOW_AW'(ptr_add(PTR_SUM_W'(slow_head_reg),
                          PTR_SUM_W'(slow_cnt_reg), PTR_SUM_W'(SLOW_DEPTH)));
    assign normal_waddr = NORMAL_AW'(ptr_add(PTR_SUM_W'(normal_head_reg),
                          PTR_SUM_W'(normal_cnt_reg), PTR_SUM_W'(NORMAL_DEPTH)));

    // lane updates; head cache refills from the entry behind the head on a pop
    always_comb
    begin
        fast_cnt_next  = fast_cnt_reg;
        fast_head_next = fast_head_reg;
        fast_hval_next = fast_hval_reg;
        if (fast_push)
        begin
            fast_cnt_next = fast_cnt_reg + 1'b1;
            if (!fast_nz)
            begin
                fast_hval_next = handle_reg;
            end
        end
        if (fast_pop)
        begin
            fast_cnt_next  = fast_cnt_reg - 1'b1;
            fast_head_next = FAST_AW'(ptr_add(PTR_SUM_W'(fast_head_reg), PTR_SUM_W'(1),
                             PTR_SUM_W'(FAST_DEPTH)));
            fast_hval_next = fast_rdata;
        end
    end

    always_comb
    begin
        slow_cnt_next  = slow_cnt_reg;
        slow_head_next = slow_head_reg;
        slow_hval_next = slow_hval_reg;
        if (slow_push)
        begin
            slow_cnt_next = slow_cnt_reg + 1'b1;
            if (!slow_nz)
            begin
                slow_hval_next = handle_reg;
            end
        end
        if (slow_pop)
        begin
            slow_cnt_next  = slow_cnt_reg - 1'b1;
            slow_head_next = SLOW_AW'(ptr_add(PTR_SUM_W'(slow_head_reg), PTR_SUM_W'(1),
                             PTR_SUM_W'(SLOW_DEPTH)));
            slow_hval_next = slow_rdata;
        end
    end

    always_comb
    begin
        normal_cnt_next  = normal_cnt_reg;
        normal_head_next = normal_head_reg;
        normal_hval_next = normal_hval_reg;
        if (normal_push)
        begin
            normal_cnt_next = normal_cnt_reg + 1'b1;
            if (!normal_nz)
            begin
                normal_hval_next = handle_reg;
            end
        end
        if (normal_pop)
        begin
            normal_cnt_next  = normal_cnt_reg - 1'b1;
            normal_head_next = NORMAL_AW'(ptr_add(PTR_SUM_W'(normal_head_reg),
                               PTR_SUM_W'(1), PTR_SUM_W'(NORMAL_DEPTH)));
            normal_hval_next = normal_rdata;
        end
    end

    assign fast_raddr   = FAST_AW'(ptr_add(PTR_SUM_W'(fast_head_next), PTR_SUM_W'(1),
                          PTR_SUM_W'(FAST_DEPTH)));
    assign slow_raddr   = SLOW_AW'(ptr_add(PTR_SUM_W'(slow_head_next), PTR_SUM_W'(1),
                          PTR_SUM_W'(SLOW_DEPTH)));
    assign normal_raddr = NORMAL_AW'(ptr_add(PTR_SUM_W'(normal_head_next), PTR_SUM_W'(1),
                          PTR_SUM_W'(NORMAL_DEPTH)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_head_reg   <= '0;
            fast_cnt_reg    <= '0;
            slow_head_reg   <= '0;
            slow_cnt_reg    <= '0;
            normal_head_reg <= '0;
            normal_cnt_reg  <= '0;
        end
        else
        begin
            fast_head_reg   <= fast_head_next;
            fast_cnt_reg    <= fast_cnt_next;
            slow_head_reg   <= slow_head_next;
            slow_cnt_reg    <= slow_cnt_next;
            normal_head_reg <= normal_head_next;
            normal_cnt_reg  <= normal_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fast_hval_reg   <= fast_hval_next;
        slow_hval_reg   <= slow_hval_next;
        normal_hval_reg <= normal_hval_next;
    end

    tlpq_ram #(
        .DEPTH (FAST_DEPTH),
        .WIDTH (ITEM_WIDTH)
    ) u_fast_ram (
        .clk   (clk),
        .we    (fast_push),
        .waddr (fast_waddr),
        .wdata (handle_reg),
        .raddr (fast_raddr),
        .rdata (fast_rdata)
    );

    tlpq_ram #(
        .DEPTH (SLOW_DEPTH),
        .WIDTH (ITEM_WIDTH)
    ) u_slow_ram (
        .clk   (clk),
        .we    (slow_push),
        .waddr (slow_waddr),
        .wdata (handle_reg),
        .raddr (slow_raddr),
        .rdata (slow_rdata)
    );

    tlpq_ram #(
        .DEPTH (NORMAL_DEPTH),
        .WIDTH (ITEM_WIDTH)
    ) u_normal_ram (
        .clk   (clk),
        .we    (normal_push),
        .waddr (normal_waddr),
        .wdata (handle_reg),
        .raddr (normal_raddr),
        .rdata (normal_rdata)
    );

    // result word
    always_comb
    begin
        accepted_next  = fast_push || slow_push || normal_push;
        out_valid_next = fast_pop || slow_pop || normal_pop;
        lane_next      = LANE_FAST;
        out_item_next  = '0;
        if (enq)
        begin
            lane_next = sel_lane;
        end
        else if (fast_pop)
        begin
            lane_next     = LANE_FAST;
            out_item_next = fast_hval_reg;
        end
        else if (slow_pop)
        begin
            lane_next     = LANE_SLOW;
            out_item_next = slow_hval_reg;
        end
        else if (normal_pop)
        begin
            lane_next     = LANE_NORMAL;
            out_item_next = normal_hval_reg;
        end

        head_valid_next = 1'b1;
        head_item_next  = '0;
        if (fast_cnt_next != '0)
        begin
            head_item_next = fast_hval_next;
        end
        else if (slow_cnt_next != '0)
        begin
            head_item_next = slow_hval_next;
        end
        else if (normal_cnt_next != '0)
        begin
            head_item_next = normal_hval_next;
        end
        else
        begin
            head_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_reg)
        begin
            accepted_reg     <= accepted_next;
            lane_reg         <= lane_next;
            out_valid_reg    <= out_valid_next;
            out_item_reg     <= out_item_next;
            head_valid_reg   <= head_valid_next;
            head_item_reg    <= head_item_next;
            fast_count_reg   <= fast_cnt_next;
            slow_count_reg   <= slow_cnt_next;
            normal_count_reg <= normal_cnt_next;
        end
    end

    assign done         = done_reg;
    assign accepted     = accepted_reg;
    assign lane_used    = lane_reg;
    assign out_valid    = out_valid_reg;
    assign out_item     = HANDLE_W'(out_item_reg);
    assign head_valid   = head_valid_reg;
    assign head_item    = HANDLE_W'(head_item_reg);
    assign fast_count   = FAST_COUNT_W'(fast_count_reg);
    assign slow_count   = SLOW_COUNT_W'(slow_count_reg);
    assign normal_count = NORMAL_COUNT_W'(normal_count_reg);

endmodule

`default_nettype wire

### rtl/tlpq_checker.sv
// Port-level checker for the three-lane priority queue, bound to the top level.
`default_nettype none
`include "three_lane_priority_queue_top_defines.svh"

module tlpq_checker
    import tlpq_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      cfg_we,
    input logic [CFG_INDEX_W-1:0]    cfg_index,
    input logic [CFG_DATA_W-1:0]     cfg_wdata,
    input logic                      opcode,
    input logic                      tag_present,
    input logic [PRI_W-1:0]          priority_value,
    input logic [HANDLE_W-1:0]       item_handle,
    input logic                      done,
    input logic                      accepted,
    input logic [1:0]                lane_used,
    input logic                      out_valid,
    input logic [HANDLE_W-1:0]       out_item,
    input logic                      head_valid,
    input logic [HANDLE_W-1:0]       head_item,
    input logic [FAST_COUNT_W-1:0]   fast_count,
    input logic [SLOW_COUNT_W-1:0]   slow_count,
    input logic [NORMAL_COUNT_W-1:0] normal_count
);

    logic                    word_in;
    logic                    lanes_nz;
    logic                    fast_step;
    logic                    fast_ok;
    logic                    prev_done_reg;
    logic [FAST_COUNT_W-1:0] fast_inc_reg;

    assign word_in   = start && !busy;
    assign lanes_nz  = (fast_count != '0) || (slow_count != '0) || (normal_count != '0);
    assign fast_step = done && prev_done_reg && accepted && (lane_used == LANE_FAST);
    assign fast_ok   = (fast_count == fast_inc_reg);

    always_ff @(posedge clk)
    begin
        prev_done_reg <= done;
        fast_inc_reg  <= fast_count + 1'b1;
    end

    // a word taken in shows its result with done once it has passed the input stage and result register
    `TLPQ_ASSERT_NEXT(a_done_after_word, $past(word_in), done, "no result for accepted word")
    `TLPQ_ASSERT_NEXT(a_no_stray_done, !$past(word_in), !done, "result without a word")
    `TLPQ_ASSERT_NOW(a_enq_deq_excl, done, !(accepted && out_valid), "enqueue and dequeue at once")
    `TLPQ_ASSERT_NOW(a_head_vs_counts, done, head_valid == lanes_nz, "head flag vs lane counts")
    `TLPQ_ASSERT_NOW(a_fast_push_count, fast_step, fast_ok, "fast count not advanced on store")

endmodule

bind three_lane_priority_queue_top tlpq_checker u_tlpq_checker (.*);

`default_nettype wire

### test/tb.sv
// Self-checking testbench for three_lane_priority_queue_top: directed table, then random phases.
`timescale 1ns / 100ps

module tb;
    import tlpq_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_WORDS  = 115;
    localparam int SCRIPT_ROWS  = 20;
    localparam int PHASE_COUNT  = 10;

    typedef struct packed {
        logic        accepted;
        logic [1:0]  lane_used;
        logic        out_valid;
        logic [31:0] out_item;
        logic        head_valid;
        logic [31:0] head_item;
        logic [5:0]  fast_count;
        logic [7:0]  slow_count;
        logic [10:0] normal_count;
    } qresult_t;

    typedef struct packed {
        op_t         op;
        logic        tag;
        logic [7:0]  pri;
        logic [31:0] handle;
        logic        typed;
        qresult_t    want;
    } script_row_t;

    typedef struct packed {
        logic [10:0] thr;
        logic [10:0] fcap;
        logic [10:0] scap;
        logic [10:0] ncap;
        logic [6:0]  enq_pct;
    } phase_t;

    localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
        '{OP_DEQUEUE, 1'b0, 8'h00, 32'h0000_0000, 1'b1, '0},
        '{OP_ENQUEUE, 1'b1, PRI_FAST, 32'hFFFF_FFFF, 1'b1,
          '{1'b1, LANE_FAST, 1'b0, 32'h0, 1'b1, 32'hFFFF_FFFF, 6'd1, 8'd0, 11'd0}},
        '{OP_ENQUEUE, 1'b1, PRI_SLOW, 32'h0000_0000, 1'b1,
          '{1'b1, LANE_SLOW, 1'b0, 32'h0, 1'b1, 32'hFFFF_FFFF, 6'd1, 8'd1, 11'd0}},
        '{OP_ENQUEUE, 1'b0, PRI_FAST, 32'h1234_5678, 1'b1,
          '{1'b1, LANE_NORMAL, 1'b0, 32'h0, 1'b1, 32'hFFFF_FFFF, 6'd1, 8'd1, 11'd1}},
        '{OP_ENQUEUE, 1'b1, 8'hFF, 32'h89AB_CDEF, 1'b0, '0},
        '{OP_ENQUEUE, 1'b1, 8'h02, 32'h5A5A_5A5A, 1'b0, '0},
        '{OP_ENQUEUE, 1'b0, PRI_SLOW, 32'hA5A5_A5A5, 1'b0, '0},
        '{OP_ENQUEUE, 1'b1, 8'h80, 32'h0F0F_0F0F, 1'b0, '0},
        '{OP_ENQUEUE, 1'b1, PRI_FAST, 32'h0000_0001, 1'b0, '0},
        '{OP_DEQUEUE, 1'b0, 8'h00, 32'h0000_0000, 1'b0, '0},
        '{OP_DEQUEUE, 1'b1, PRI_FAST, 32'h0000_0000, 1'b0, '0},
        '{OP_DEQUEUE, 1'b1, PRI_SLOW, 32'hFFFF_FFFF, 1'b0, '0},
        '{OP_DEQUEUE, 1'b0, 8'hFF, 32'h0000_0000, 1'b0, '0},
        '{OP_DEQUEUE, 1'b0, 8'h00, 32'h0000_0000, 1'b0, '0},
        '{OP_DEQUEUE, 1'b0, 8'h00, 32'h0000_0000, 1'b0, '0},
        '{OP_DEQUEUE, 1'b0, 8'h00, 32'h0000_0000, 1'b0, '0},
        '{OP_DEQUEUE, 1'b0, 8'h00, 32'h0000_0000, 1'b0, '0},
        '{OP_DEQUEUE, 1'b1, 8'hFF, 32'hFFFF_FFFF, 1'b1, '0},
        '{OP_ENQUEUE, 1'b1, 8'h7F, 32'hF0F0_F0F0, 1'b0, '0},
        '{OP_DEQUEUE, 1'b0, PRI_SLOW, 32'h0000_0000, 1'b0, '0}
    };

    // threshold zero, caps zero, caps above lane depth, masked writes
    localparam phase_t PHASES [PHASE_COUNT] = '{
        '{11'd17,   11'd17,   11'd68,   11'd1000, 7'd60},
        '{11'd0,    11'd32,   11'd8,    11'd4,    7'd70},
        '{11'd63,   11'd63,   11'd255,  11'd2047, 7'd65},
        '{11'd4,    11'd6,    11'd3,    11'd2,    7'd75},
        '{11'd32,   11'd0,    11'd0,    11'd0,    7'd50},
        '{11'd2,    11'd1,    11'd1,    11'd1,    7'd60},
        '{11'd20,   11'd32,   11'd128,  11'd1024, 7'd80},
        '{11'd8,    11'd16,   11'd40,   11'd1000, 7'd30},
        '{11'h7C5,  11'h7C9,  11'h70C,  11'h400,  7'd70},
        '{11'd17,   11'd17,   11'd68,   11'd1000, 7'd50}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      cfg_we;
    cfg_index_t                cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_wdata;
    logic                      opcode;
    logic                      tag_present;
    logic [PRI_W-1:0]          priority_value;
    logic [HANDLE_W-1:0]       item_handle;
    logic                      done;
    logic                      accepted;
    logic [1:0]                lane_used;
    logic                      out_valid;
    logic [HANDLE_W-1:0]       out_item;
    logic                      head_valid;
    logic [HANDLE_W-1:0]       head_item;
    logic [FAST_COUNT_W-1:0]   fast_count;
    logic [SLOW_COUNT_W-1:0]   slow_count;
    logic [NORMAL_COUNT_W-1:0] normal_count;

    three_lane_priority_queue_top u_dut (.*);

    logic [31:0] fast_q [$];
    logic [31:0] slow_q [$];
    logic [31:0] normal_q [$];
    logic [5:0]  divert_thr;
    logic [5:0]  fast_cap;
    logic [7:0]  slow_cap;
    logic [10:0] normal_cap;

    qresult_t pending_results [$];
    qresult_t oldest;
    int       failures;
    int       run_left;
    logic     run_idle;
    int       cycles;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic qresult_t queue_step(op_t op, logic tag, logic [7:0] pri,
                                            logic [31:0] handle);
        qresult_t r;
        lane_t    ln;
        r = '0;
        if (op == OP_ENQUEUE) begin
            ln = LANE_NORMAL;
            if (tag && pri == PRI_FAST)
                ln = LANE_FAST;
            else if (tag && pri == PRI_SLOW)
                ln = LANE_SLOW;
            if (ln == LANE_FAST && fast_q.size() >= divert_thr)
                ln = LANE_SLOW;
            r.lane_used = ln;
            case (ln)
                LANE_FAST:
                    if (fast_q.size() < ((fast_cap < FAST_DEPTH) ? fast_cap : FAST_DEPTH))
                    begin
                        fast_q.push_back(handle);
                        r.accepted = 1'b1;
                    end
                LANE_SLOW:
                    if (slow_q.size() < ((slow_cap < SLOW_DEPTH) ? slow_cap : SLOW_DEPTH))
                    begin
                        slow_q.push_back(handle);
                        r.accepted = 1'b1;
                    end
                default:
                    if (normal_q.size() <
                        ((normal_cap < NORMAL_DEPTH) ? normal_cap : NORMAL_DEPTH))
                    begin
                        normal_q.push_back(handle);
                        r.accepted = 1'b1;
                    end
            endcase
        end else begin
            if (fast_q.size() != 0) begin
                r.out_valid = 1'b1;
                r.out_item  = fast_q.pop_front();
                r.lane_used = LANE_FAST;
            end else if (slow_q.size() != 0) begin
                r.out_valid = 1'b1;
                r.out_item  = slow_q.pop_front();
                r.lane_used = LANE_SLOW;
            end else if (normal_q.size() != 0) begin
                r.out_valid = 1'b1;
                r.out_item  = normal_q.pop_front();
                r.lane_used = LANE_NORMAL;
            end
        end
        if (fast_q.size() != 0) begin
            r.head_valid = 1'b1;
            r.head_item  = fast_q[0];
        end else if (slow_q.size() != 0) begin
            r.head_valid = 1'b1;
            r.head_item  = slow_q[0];
        end else if (normal_q.size() != 0) begin
            r.head_valid = 1'b1;
            r.head_item  = normal_q[0];
        end
        r.fast_count   = fast_q.size();
        r.slow_count   = slow_q.size();
        r.normal_count = normal_q.size();
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    task automatic send_word(op_t op, logic tag, logic [7:0] pri, logic [31:0] handle,
                             logic typed, qresult_t want);
        qresult_t predicted;
        int       gap;
        @(negedge clk);
        start          <= 1'b1;
        opcode         <= op;
        tag_present    <= tag;
        priority_value <= pri;
        item_handle    <= handle;
        do @(posedge clk); while (busy);
        predicted = queue_step(op, tag, pri, handle);
        pending_results.push_back(typed ? want : predicted);
        if (run_left == 0) begin
            run_idle = $urandom_range(0, 1);
            run_left = $urandom_range(4, 30);
        end
        run_left--;
        gap = run_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // drain all words in flight and leave start low
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic cfg_write(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_THRESHOLD: divert_thr = data[5:0];
            CFG_FAST_CAP:  fast_cap   = data[5:0];
            CFG_SLOW_CAP:  slow_cap   = data[7:0];
            default:       normal_cap = data[10:0];
        endcase
    endtask

    always @(posedge clk) begin
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing pending");
                failures++;
            end else begin
                oldest = pending_results.pop_front();
                check_field("accepted", oldest.accepted, accepted);
                check_field("lane_used", oldest.lane_used, lane_used);
                check_field("out_valid", oldest.out_valid, out_valid);
                check_field("out_item", oldest.out_item, out_item);
                check_field("head_valid", oldest.head_valid, head_valid);
                check_field("head_item", oldest.head_item, head_item);
                check_field("fast_count", oldest.fast_count, fast_count);
                check_field("slow_count", oldest.slow_count, slow_count);
                check_field("normal_count", oldest.normal_count, normal_count);
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("[three_lane_priority_queue_top] ERROR");
        $finish;
    end

    initial begin
        op_t         op;
        logic        tag;
        logic [7:0]  pri;
        int          r;
        rst_n          = 1'b0;
        start          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_THRESHOLD;
        cfg_wdata      = '0;
        opcode         = OP_ENQUEUE;
        tag_present    = 1'b0;
        priority_value = '0;
        item_handle    = '0;
        failures       = 0;
        run_left       = 0;
        run_idle       = 1'b0;
        divert_thr     = THR_RESET;
        fast_cap       = FAST_CAP_RESET;
        slow_cap       = SLOW_CAP_RESET;
        normal_cap     = NORMAL_CAP_RESET;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (SCRIPT[i])
            send_word(SCRIPT[i].op, SCRIPT[i].tag, SCRIPT[i].pri, SCRIPT[i].handle,
                      SCRIPT[i].typed, SCRIPT[i].want);

        foreach (PHASES[p]) begin
            settle();
            cfg_write(CFG_THRESHOLD, PHASES[p].thr);
            cfg_write(CFG_FAST_CAP, PHASES[p].fcap);
            cfg_write(CFG_SLOW_CAP, PHASES[p].scap);
            cfg_write(CFG_NORMAL_CAP, PHASES[p].ncap);
            repeat (PHASE_WORDS) begin
                op  = ($urandom_range(0, 99) < PHASES[p].enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
                tag = ($urandom_range(0, 9) != 0);
                r   = $urandom_range(0, 9);
                if (r < 4)
                    pri = PRI_FAST;
                else if (r < 6)
                    pri = PRI_SLOW;
                else
                    pri = $urandom_range(0, 255);
                send_word(op, tag, pri, $urandom, 1'b0, '0);
            end
        end

        settle();
        if (failures == 0)
            $display("[three_lane_priority_queue_top] OK");
        else
            $display("[three_lane_priority_queue_top] ERROR");
        $finish;
    end

endmodule
